[src/fpc_pkg.sv]
// Shared codes, constants and types for the binary32/binary16 converter.
`timescale 1ns / 1ps

package fpc_pkg;

	// Operation codes carried by func
	typedef enum logic [1:0] {
		FUNC_S2H     = 2'd0,
		FUNC_H2S     = 2'd1,
		FUNC_ROUND   = 2'd2,
		FUNC_S2H_ALT = 2'd3
	} func_t;

	// binary16 special patterns (sign excluded)
	localparam logic [14:0] HALF_INF   = 15'h7c00;
	localparam logic [14:0] HALF_QNAN  = 15'h7e00;
	localparam logic [9:0]  HALF_MANT  = 10'h3ff;

	// binary32 and binary16 exponent field limits
	localparam logic [7:0]  SINGLE_EXP_MAX = 8'hff;
	localparam logic [4:0]  HALF_EXP_MAX   = 5'h1f;

	// Exponent rebias between formats: 127 - 15
	localparam logic [7:0]  EXP_REBIAS     = 8'd112;
	// Single exponents that bound the half ranges
	localparam logic [7:0]  EXP_UNDERFLOW  = 8'd102;
	localparam logic [7:0]  EXP_SUBNORMAL  = 8'd112;
	localparam logic [7:0]  EXP_OVERFLOW   = 8'd143;
	// Subnormal shift is 126 - exponent, its guard position one less
	localparam logic [7:0]  SUB_SHIFT_BASE = 8'd126;
	localparam logic [7:0]  SUB_GUARD_BASE = 8'd125;
	// Single exponent of a half subnormal whose top bit is bit 0
	localparam logic [7:0]  SUB_EXP_BASE   = 8'd103;

	// One pipeline stage's payload
	typedef struct packed {
		func_t       func;
		logic [31:0] single_val;
		logic [15:0] half_val;
	} stage_t;

endpackage

[src/fpc_s2h.sv]
// binary32 to binary16 conversion, round to nearest even.
`timescale 1ns / 1ps

module fpc_s2h import fpc_pkg::*; (
	input  logic [31:0] single_in,
	output logic [15:0] half_res
);

	logic        sgn;
	logic [7:0]  fexp;
	logic [22:0] man;
	logic [23:0] man_ext;
	logic [4:0]  hexp;
	logic        up_n;
	logic [14:0] norm_sum;
	logic [4:0]  sh;
	logic [4:0]  sh_m1;
	logic [23:0] shifted;
	logic        guard_s;
	logic        sticky_s;
	logic        up_s;
	logic [10:0] sub_res;

	always_comb begin
		sgn     = single_in[31];
		fexp    = single_in[30:23];
		man     = single_in[22:0];
		man_ext = {1'b1, man};

		// Normal half: round the top ten mantissa bits, carry may reach the exponent
		hexp     = 5'(fexp - EXP_REBIAS);
		up_n     = man[12] && ((|man[11:0]) || man[13]);
		norm_sum = {hexp, man[22:13]} + 15'(up_n);

		// Subnormal half: shift the full significand right, then round
		sh       = 5'(SUB_SHIFT_BASE - fexp);
		sh_m1    = 5'(SUB_GUARD_BASE - fexp);
		shifted  = man_ext >> sh;
		guard_s  = |(man_ext & (24'd1 << sh_m1));
		sticky_s = |(man_ext & ((24'd1 << sh_m1) - 24'd1));
		up_s     = guard_s && (sticky_s || shifted[0]);
		sub_res  = shifted[10:0] + 11'(up_s);

		// Pick the range the exponent falls in
		if (fexp == SINGLE_EXP_MAX) begin
			half_res = {sgn, (man == 23'd0) ? HALF_INF : HALF_QNAN};
		end else if (fexp < EXP_UNDERFLOW) begin
			half_res = {sgn, 15'd0};
		end else if (fexp <= EXP_SUBNORMAL) begin
			half_res = {sgn, 4'd0, sub_res};
		end else if (fexp >= EXP_OVERFLOW) begin
			half_res = {sgn, HALF_INF};
		end else begin
			half_res = {sgn, norm_sum};
		end
	end

endmodule

[src/fpc_h2s.sv]
// binary16 to binary32 conversion, exact, subnormals normalised.
`timescale 1ns / 1ps

module fpc_h2s import fpc_pkg::*; (
	input  logic [15:0] half_in,
	output logic [31:0] single_res
);

	logic        sgn;
	logic [4:0]  ex;
	logic [9:0]  man;
	logic [3:0]  msb_pos;
	logic [3:0]  norm_sh;
	logic [9:0]  man_norm;
	logic [7:0]  sub_exp;

	always_comb begin
		sgn = half_in[15];
		ex  = half_in[14:10];
		man = half_in[9:0] & HALF_MANT;

		// Find the leading one of a subnormal mantissa
		msb_pos = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (man[i]) begin
				msb_pos = 4'(i);
			end
		end
		norm_sh  = 4'd10 - msb_pos;
		man_norm = 10'(man << norm_sh);
		sub_exp  = SUB_EXP_BASE + 8'(msb_pos);

		if (ex == 5'd0) begin
			if (man == 10'd0) begin
				single_res = {sgn, 31'd0};
			end else begin
				single_res = {sgn, sub_exp, man_norm, 13'd0};
			end
		end else if (ex == HALF_EXP_MAX) begin
			single_res = {sgn, SINGLE_EXP_MAX, man, 13'd0};
		end else begin
			single_res = {sgn, 8'(ex) + EXP_REBIAS, man, 13'd0};
		end
	end

endmodule

[src/fp16_fp32_converter_core.sv]
// Top level: input register, binary32/binary16 conversion logic, result register.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------------------------
//  input   | in_valid  | in_stall  | func, in_single, in_half
//  output  | out_valid | out_stall | half_out, single_out
//
//  One item accepted per cycle while the output is not stalled; it passes through the
//  input register and then the result register before its result can transfer.
//  Both conversion units sit between the input and result registers, so a new item
//  can enter every cycle while the output is not stalled.
//  Reset clears the valid bits only; payload registers are not reset.
//  A stall on the output holds the result and backs up to the input once the input
//  register is also full.
`timescale 1ns / 1ps

module fp16_fp32_converter_core import fpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] in_single,
	input  logic [15:0] in_half,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] half_out,
	output logic [31:0] single_out
);

	stage_t      stage_s1;
	logic        valid_s1;
	logic        valid_q;
	logic [15:0] half_q;
	logic [31:0] single_q;
	logic        en_out;
	logic        en_s1;
	logic [15:0] half_conv;
	logic [31:0] single_conv;
	logic [15:0] h2s_operand;

	// Advance a stage when it is empty or the next one moves
	assign en_out   = !valid_q || !out_stall;
	assign en_s1    = !valid_s1 || en_out;
	assign in_stall = !en_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			stage_s1.func       <= func_t'(func);
			stage_s1.single_val <= in_single;
			stage_s1.half_val   <= in_half;
		end
	end

	fpc_s2h u_s2h (
		.single_in (stage_s1.single_val),
		.half_res  (half_conv)
	);

	// Widen the half operand for half-to-single, else the freshly narrowed half
	assign h2s_operand = (stage_s1.func == FUNC_H2S) ? stage_s1.half_val : half_conv;

	fpc_h2s u_h2s (
		.half_in    (h2s_operand),
		.single_res (single_conv)
	);

	// Result register; drop the field the operation does not produce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en_out) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && valid_s1) begin
			case (stage_s1.func)
				FUNC_H2S: begin
					half_q   <= 16'd0;
					single_q <= single_conv;
				end
				FUNC_ROUND: begin
					half_q   <= half_conv;
					single_q <= single_conv;
				end
				default: begin
					half_q   <= half_conv;
					single_q <= 32'd0;
				end
			endcase
		end
	end

	assign out_valid  = valid_q;
	assign half_out   = half_q;
	assign single_out = single_q;

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the binary32/binary16 format converter core.
`timescale 1ns / 1ps

module tb_top;
	import fpc_pkg::*;

	localparam int PHASE_ITEMS   = 213;
	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 8;
	localparam logic [12:0] ROUND_TIE    = 13'h1000;
	localparam logic [10:0] MANT_CARRY   = 11'h400;
	localparam logic [7:0]  SUB_TOP_EXP  = EXP_REBIAS + 8'd1;

	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct {
		func_t       op;
		logic [31:0] single_bits;
		logic [15:0] half_bits;
	} conv_req_t;

	typedef struct {
		logic [15:0] half_bits;
		logic [31:0] single_bits;
	} conv_res_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic [1:0]  func       = '0;
	logic [31:0] in_single  = '0;
	logic [15:0] in_half    = '0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [15:0] half_out;
	logic [31:0] single_out;

	conv_req_t  conv_req_q[$];
	conv_res_t  predicted_conv_q[$];
	conv_req_t  next_req;
	conv_req_t  seen_req;
	conv_res_t  want;
	idle_mode_t idle_mode = IDLE_NONE;
	int         send_pct;
	int         stall_pct;
	int         issued_count   = 0;
	int         accepted_count = 0;
	int         error_count    = 0;
	int         quiet_cycles   = 0;
	logic       in_taken       = 1'b0;

	fp16_fp32_converter_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.in_single  (in_single),
		.in_half    (in_half),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.half_out   (half_out),
		.single_out (single_out)
	);

	always #4 clk = ~clk;

	assign send_pct  = (idle_mode == IDLE_SEND) ? 77 : (idle_mode == IDLE_BOTH) ? 38 : 0;
	assign stall_pct = (idle_mode == IDLE_RECV) ? 77 : (idle_mode == IDLE_BOTH) ? 38 : 0;

	// Round a binary32 pattern to binary16, nearest even
	function automatic logic [15:0] narrow_single(logic [31:0] f);
		logic        sgn;
		logic [7:0]  fexp;
		logic [31:0] man;
		logic [31:0] hm;
		logic [31:0] rem;
		logic [31:0] halfway;
		int          e;
		int          sh;
		sgn  = f[31];
		fexp = f[30:23];
		man  = {9'd0, f[22:0]};
		if (fexp == SINGLE_EXP_MAX) begin
			return {sgn, (f[22:0] == '0) ? HALF_INF : HALF_QNAN};
		end
		e = int'(fexp) - int'(EXP_REBIAS);
		// Half subnormal range: shift in the hidden bit and round
		if (e <= 0) begin
			if (e < -10) begin
				return {sgn, 15'd0};
			end
			man[23]  = 1'b1;
			sh       = 14 - e;
			hm       = man >> sh;
			rem      = man & ((32'd1 << sh) - 32'd1);
			halfway  = 32'd1 << (sh - 1);
			if (rem > halfway || (rem == halfway && hm[0])) begin
				hm = hm + 32'd1;
			end
			return {sgn, hm[14:0]};
		end
		if (e >= int'(HALF_EXP_MAX)) begin
			return {sgn, HALF_INF};
		end
		hm  = man >> 13;
		rem = {19'd0, man[12:0]};
		if (rem > ROUND_TIE || (rem == ROUND_TIE && hm[0])) begin
			hm = hm + 32'd1;
			// Carry out of the mantissa bumps the exponent
			if (hm[10:0] == MANT_CARRY) begin
				hm = '0;
				e  = e + 1;
				if (e >= int'(HALF_EXP_MAX)) begin
					return {sgn, HALF_INF};
				end
			end
		end
		return {sgn, 5'(e), hm[9:0]};
	endfunction

	// Widen a binary16 pattern to binary32 exactly
	function automatic logic [31:0] widen_half(logic [15:0] h);
		logic        sgn;
		logic [4:0]  ex;
		logic [10:0] man;
		logic [7:0]  fe;
		sgn = h[15];
		ex  = h[14:10];
		man = {1'b0, h[9:0]};
		if (ex == '0) begin
			if (man == '0) begin
				return {sgn, 31'd0};
			end
			// Normalise the subnormal
			fe = SUB_TOP_EXP;
			while (man[10] == 1'b0) begin
				man = man << 1;
				fe  = fe - 8'd1;
			end
			return {sgn, fe, man[9:0], 13'd0};
		end
		if (ex == HALF_EXP_MAX) begin
			return {sgn, SINGLE_EXP_MAX, man[9:0], 13'd0};
		end
		return {sgn, {3'd0, ex} + EXP_REBIAS, man[9:0], 13'd0};
	endfunction

	function automatic conv_res_t convert_item(conv_req_t r);
		conv_res_t res;
		res.half_bits   = '0;
		res.single_bits = '0;
		case (r.op)
			FUNC_H2S: begin
				res.single_bits = widen_half(r.half_bits);
			end
			FUNC_ROUND: begin
				res.half_bits   = narrow_single(r.single_bits);
				res.single_bits = widen_half(res.half_bits);
			end
			default: begin
				res.half_bits = narrow_single(r.single_bits);
			end
		endcase
		return res;
	endfunction

	task automatic queue_conversion(func_t op, logic [31:0] s, logic [15:0] h);
		conv_req_t r;
		r.op          = op;
		r.single_bits = s;
		r.half_bits   = h;
		conv_req_q.push_back(r);
		issued_count++;
	endtask

	// Drive the input channel: hold a stalled transfer, else load or idle
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (conv_req_q.size() != 0 && $urandom_range(0, 99) >= send_pct) begin
				next_req  = conv_req_q.pop_front();
				in_valid  <= 1'b1;
				func      <= next_req.op;
				in_single <= next_req.single_bits;
				in_half   <= next_req.half_bits;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Drive the output stall
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Check results in order, then record the prediction for a new transfer
	always @(posedge clk) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				if (predicted_conv_q.size() == 0) begin
					$display("%0t: unexpected result half_out %h single_out %h",
						$time, half_out, single_out);
					error_count++;
				end else begin
					want = predicted_conv_q.pop_front();
					if (half_out !== want.half_bits) begin
						$display("%0t: half_out expected %h, actual %h",
							$time, want.half_bits, half_out);
						error_count++;
					end
					if (single_out !== want.single_bits) begin
						$display("%0t: single_out expected %h, actual %h",
							$time, want.single_bits, single_out);
						error_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				seen_req.op          = func_t'(func);
				seen_req.single_bits = in_single;
				seen_req.half_bits   = in_half;
				predicted_conv_q.push_back(convert_item(seen_req));
				accepted_count++;
			end
		end
	end

	// Abort when no transfer happens on either side for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		idle_mode_t modes[4];
		func_t       op;
		logic [31:0] s;
		logic [15:0] h;
		int          ex;
		int          sh;
		modes[0] = IDLE_NONE;
		modes[1] = IDLE_SEND;
		modes[2] = IDLE_RECV;
		modes[3] = IDLE_BOTH;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 4; ph++) begin
			@(posedge clk);
			idle_mode = modes[ph];
			if (ph == 0) begin
				// Zeros, infinities, NaNs, rounding ties and range edges
				queue_conversion(FUNC_S2H,     32'h0000_0000, 16'hffff);
				queue_conversion(FUNC_S2H_ALT, 32'h8000_0000, 16'h0000);
				queue_conversion(FUNC_S2H,     32'hff80_0000, 16'hffff);
				queue_conversion(FUNC_ROUND,   32'h7f80_0000, 16'h0000);
				queue_conversion(FUNC_S2H,     32'h7fc0_0001, 16'hffff);
				queue_conversion(FUNC_ROUND,   32'hffa0_0000, 16'h0000);
				queue_conversion(FUNC_S2H,     32'h0000_0001, 16'hffff);
				queue_conversion(FUNC_S2H,     32'h477f_efff, 16'h0000);
				queue_conversion(FUNC_ROUND,   32'h477f_f000, 16'hffff);
				queue_conversion(FUNC_S2H,     32'h7f7f_ffff, 16'h0000);
				queue_conversion(FUNC_S2H,     32'h3300_0000, 16'hffff);
				queue_conversion(FUNC_ROUND,   32'h3300_0001, 16'h0000);
				queue_conversion(FUNC_S2H_ALT, 32'h387f_e000, 16'hffff);
				queue_conversion(FUNC_S2H,     32'h3f80_1000, 16'h0000);
				queue_conversion(FUNC_ROUND,   32'h3f80_3000, 16'hffff);
				queue_conversion(FUNC_S2H,     32'hffff_ffff, 16'h0000);
				queue_conversion(FUNC_H2S,     32'hffff_ffff, 16'h0000);
				queue_conversion(FUNC_H2S,     32'h0000_0000, 16'h8001);
				queue_conversion(FUNC_H2S,     32'hffff_ffff, 16'h03ff);
				queue_conversion(FUNC_H2S,     32'h0000_0000, 16'h0400);
				queue_conversion(FUNC_H2S,     32'hffff_ffff, 16'h7bff);
				queue_conversion(FUNC_H2S,     32'h0000_0000, 16'hfc00);
				queue_conversion(FUNC_H2S,     32'hffff_ffff, 16'h7c01);
				queue_conversion(FUNC_H2S,     32'h0000_0000, 16'hffff);
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				op = func_t'($urandom_range(0, 3));
				s  = $urandom;
				case ($urandom_range(0, 5))
					1, 2: begin
						// Exponents around the half range
						s[30:23] = 8'($urandom_range(98, 146));
					end
					3: begin
						// Exact rounding ties, normal and subnormal
						ex = $urandom_range(103, 142);
						s[30:23] = 8'(ex);
						if (ex > int'(EXP_SUBNORMAL)) begin
							s[12:0] = ROUND_TIE;
						end else begin
							sh = int'(SUB_SHIFT_BASE) - ex;
							s  = (s & ~((32'd1 << sh) - 32'd1)) | (32'd1 << (sh - 1));
						end
					end
					4: begin
						// Zero or all-ones exponent, mantissa sometimes clear
						s[30:23] = $urandom_range(0, 1) ? SINGLE_EXP_MAX : 8'h00;
						if ($urandom_range(0, 2) == 0) begin
							s[22:0] = '0;
						end
					end
					5: begin
						// Near overflow with a full mantissa
						s[30:23] = 8'($urandom_range(140, 143));
						s[22:13] = HALF_MANT;
					end
					default: begin
					end
				endcase
				h = 16'($urandom);
				if ($urandom_range(0, 3) == 0) begin
					h[14:10] = $urandom_range(0, 1) ? HALF_EXP_MAX : 5'h00;
				end
				queue_conversion(op, s, h);
			end
			// Hold off until every transfer of the phase has come back
			do begin
				@(negedge clk);
			end while (accepted_count != issued_count || predicted_conv_q.size() != 0);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
